// ===== design/assert_macros.svh =====
// Assertion macros shared by the frame ring queue modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");
// The condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/frq_pkg.sv =====
// Package with the types, constants and helper functions of the frame ring queue.
package frq_pkg;

    // Storage geometry.
    localparam int SLOTS       = 16;
    localparam int FRAME_BYTES = 64;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int ADDR_W      = $clog2(SLOTS * FRAME_BYTES);

    // Field widths of the beats.
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int STATUS_W = 2;

    // Configuration port.
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int SLOTS_CFG_W   = 5;
    localparam int LIMIT_CFG_W   = 7;
    localparam logic [SLOTS_CFG_W-1:0] ACTIVE_SLOTS_RST = 5'd16;
    localparam logic [LIMIT_CFG_W-1:0] FRAME_LIMIT_RST  = 7'd64;
    localparam logic REG_ACTIVE_SLOTS = 1'b0;
    localparam logic REG_FRAME_LIMIT  = 1'b1;

    // Job queue between the front and back ends.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam logic [QPTR_W:0] QCNT_FULL = (QPTR_W + 1)'(QDEPTH);
    localparam int PEND_W = $clog2(QDEPTH + 1);
    localparam logic [PEND_W-1:0] PEND_MAX = PEND_W'(QDEPTH);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 2'd0,
        CMD_READ    = 2'd1,
        CMD_DISCARD = 2'd2,
        CMD_CLEAR   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_TOO_LONG = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // One unit of work for the back end: a single result, or a burst over a stored frame.
    typedef struct packed {
        logic              burst;
        t_status           status;
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] slot;
    } t_job;

    // First byte address of a slot in the frame store.
    function automatic logic [ADDR_W-1:0] slot_base(input logic [SLOT_W-1:0] slot);
        return ADDR_W'(slot) * ADDR_W'(FRAME_BYTES);
    endfunction

endpackage

// ===== design/frq_if.sv =====
// Valid/ready channel interfaces for input items and result beats.
interface frq_in_if;
    logic                      valid;
    logic                      ready;
    logic [frq_pkg::CMD_W-1:0]  cmd;
    logic [frq_pkg::BYTE_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, cmd, data_byte, last_byte, input ready);
    modport sink   (input valid, cmd, data_byte, last_byte, output ready);
endinterface

interface frq_out_if;
    logic                        valid;
    logic                        ready;
    logic [frq_pkg::STATUS_W-1:0] status;
    logic [frq_pkg::BYTE_W-1:0]   out_byte;
    logic                        byte_valid;
    logic [frq_pkg::LEN_W-1:0]    frame_length;
    logic                        last;

    modport source (output valid, status, out_byte, byte_valid, frame_length, last,
                    input ready);
    modport sink   (input valid, status, out_byte, byte_valid, frame_length, last,
                    output ready);
endinterface

// ===== design/frame_ring_queue.sv =====
// Frame ring queue top level: configuration registers, front end, job queue, back end, frame store.
// Jobs pass the job queue, stage A and output register; a full queue or busy receiver stalls them.
// Unstalled throughput: one item per cycle for appends, discards, clears; one read byte per cycle.
// An append is held off until every queued frame read has fetched all its bytes from the store.
// Reset (synchronous, active low) empties the ring and restores 16 slots and a 64-byte limit;
// frame bytes and lengths are not cleared, and no clearing pass runs after reset.
module frame_ring_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    frq_in_if.sink                        i_item,
    frq_out_if.source                     o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frq_pkg::PADDR_W-1:0]   paddr,
    input  logic [frq_pkg::PDATA_W-1:0]   pwdata,
    output logic [frq_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    logic [frq_pkg::SLOTS_CFG_W-1:0] r_active_slots;
    logic [frq_pkg::LIMIT_CFG_W-1:0] r_frame_limit;
    logic                            cfg_wr;

    logic                            q_push;
    frq_pkg::t_job                   q_in_job;
    logic                            q_full;
    logic                            q_pop;
    frq_pkg::t_job                   q_out_job;
    logic                            q_empty;
    logic                            burst_done;

    logic                            wr_en;
    logic [frq_pkg::ADDR_W-1:0]      wr_addr;
    logic [frq_pkg::BYTE_W-1:0]      wr_data;
    logic                            rd_en;
    logic [frq_pkg::ADDR_W-1:0]      rd_addr;
    logic [frq_pkg::BYTE_W-1:0]      rd_data;

    // Configuration registers, written in the access phase of a write.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slots <= frq_pkg::ACTIVE_SLOTS_RST;
            r_frame_limit  <= frq_pkg::FRAME_LIMIT_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                frq_pkg::REG_ACTIVE_SLOTS: r_active_slots <= pwdata[frq_pkg::SLOTS_CFG_W-1:0];
                frq_pkg::REG_FRAME_LIMIT:  r_frame_limit  <= pwdata[frq_pkg::LIMIT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            frq_pkg::REG_ACTIVE_SLOTS: prdata = frq_pkg::PDATA_W'(r_active_slots);
            frq_pkg::REG_FRAME_LIMIT:  prdata = frq_pkg::PDATA_W'(r_frame_limit);
            default:                   prdata = '0;
        endcase
    end

    frq_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item         (i_item),
        .i_active_slots (r_active_slots),
        .i_frame_limit  (r_frame_limit),
        .o_push         (q_push),
        .o_job          (q_in_job),
        .i_q_full       (q_full),
        .i_burst_done   (burst_done),
        .o_wr_en        (wr_en),
        .o_wr_addr      (wr_addr),
        .o_wr_data      (wr_data)
    );

    frq_job_fifo u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (q_out_job),
        .o_empty (q_empty)
    );

    frq_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (q_out_job),
        .i_q_empty    (q_empty),
        .o_pop        (q_pop),
        .o_burst_done (burst_done),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_result     (o_result)
    );

    // Frame store: one fixed-size slot per frame.
    frq_ram #(
        .WIDTH (frq_pkg::BYTE_W),
        .DEPTH (frq_pkg::SLOTS * frq_pkg::FRAME_BYTES)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

// ===== design/frq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module frq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port, and a read port whose output holds while it is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/frq_job_fifo.sv =====
// Short job queue that decouples the command front end from the result back end.
module frq_job_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  frq_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output frq_pkg::t_job o_job,
    output logic          o_empty
);

    frq_pkg::t_job               r_mem [frq_pkg::QDEPTH];
    logic [frq_pkg::QPTR_W-1:0]  r_wp;
    logic [frq_pkg::QPTR_W-1:0]  r_rp;
    logic [frq_pkg::QPTR_W:0]    r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end else begin
                r_cnt <= r_cnt;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == frq_pkg::QCNT_FULL);
    assign o_empty = (r_cnt == '0);

endmodule

// ===== design/frq_front.sv =====
// Front end: accepts items, keeps the ring state and frame lengths, writes bytes, queues jobs.
`include "assert_macros.svh"

module frq_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    frq_in_if.sink                          i_item,
    input  logic [frq_pkg::SLOTS_CFG_W-1:0] i_active_slots,
    input  logic [frq_pkg::LIMIT_CFG_W-1:0] i_frame_limit,
    output logic                            o_push,
    output frq_pkg::t_job                   o_job,
    input  logic                            i_q_full,
    input  logic                            i_burst_done,
    output logic                            o_wr_en,
    output logic [frq_pkg::ADDR_W-1:0]      o_wr_addr,
    output logic [frq_pkg::BYTE_W-1:0]      o_wr_data
);

    logic [frq_pkg::SLOT_W-1:0] r_head, n_head;
    logic [frq_pkg::SLOT_W-1:0] r_tail, n_tail;
    logic [frq_pkg::CNT_W-1:0]  r_count, n_count;
    logic [frq_pkg::LEN_W-1:0]  r_wlen, n_wlen;
    logic                       r_open, n_open;
    frq_pkg::t_status           r_reject, n_reject;
    logic [frq_pkg::PEND_W-1:0] r_rd_pend, n_rd_pend;
    logic [frq_pkg::LEN_W-1:0]  r_len_store [frq_pkg::SLOTS];

    logic [frq_pkg::CNT_W-1:0]  eff_slots;
    logic [frq_pkg::LEN_W-1:0]  eff_limit;
    frq_pkg::t_cmd              cmd;
    logic                       acc;
    frq_pkg::t_status           open_rej;
    logic [frq_pkg::LEN_W-1:0]  cur_len;
    logic [frq_pkg::LEN_W-1:0]  head_len;
    logic                       len_we;
    logic [frq_pkg::LEN_W-1:0]  len_wdata;

    // Next ring position, wrapping at the number of slots in use.
    function automatic logic [frq_pkg::SLOT_W-1:0] step_index(
        input logic [frq_pkg::SLOT_W-1:0] idx,
        input logic [frq_pkg::CNT_W-1:0]  lim
    );
        logic [frq_pkg::CNT_W-1:0] inc;
        inc = frq_pkg::CNT_W'(idx) + frq_pkg::CNT_W'(1);
        return (inc >= lim) ? '0 : frq_pkg::SLOT_W'(inc);
    endfunction

    // Register values saturated into their legal ranges.
    always_comb begin
        priority if (i_active_slots == '0) begin
            eff_slots = frq_pkg::CNT_W'(1);
        end else if (int'(i_active_slots) > frq_pkg::SLOTS) begin
            eff_slots = frq_pkg::SLOTS_CNT;
        end else begin
            eff_slots = frq_pkg::CNT_W'(i_active_slots);
        end
        priority if (i_frame_limit == '0) begin
            eff_limit = frq_pkg::LEN_W'(1);
        end else if (int'(i_frame_limit) > frq_pkg::FRAME_BYTES) begin
            eff_limit = frq_pkg::LEN_W'(frq_pkg::FRAME_BYTES);
        end else begin
            eff_limit = i_frame_limit;
        end
    end

    // An append waits while any frame read is still queued or fetching bytes, so a
    // slot being read is never overwritten.
    assign cmd          = frq_pkg::t_cmd'(i_item.cmd);
    assign i_item.ready = !i_q_full && ((cmd != frq_pkg::CMD_APPEND) || (r_rd_pend == '0));
    assign acc          = i_item.valid && i_item.ready;

    // Frame state as seen by this byte: a new frame checks for a free slot.
    assign open_rej = r_open ? r_reject :
                      ((r_count >= eff_slots) ? frq_pkg::ST_FULL : frq_pkg::ST_OK);
    assign cur_len  = r_open ? r_wlen : '0;
    assign head_len = r_len_store[r_head];

    // Command decode and ring state update.
    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_count   = r_count;
        n_wlen    = r_wlen;
        n_open    = r_open;
        n_reject  = r_reject;
        n_rd_pend = r_rd_pend;
        o_push    = 1'b0;
        o_job     = '{burst: 1'b0, status: frq_pkg::ST_OK, len: '0, slot: '0};
        o_wr_en   = 1'b0;
        o_wr_addr = frq_pkg::slot_base(r_tail) + frq_pkg::ADDR_W'(cur_len);
        o_wr_data = i_item.data_byte;
        len_we    = 1'b0;
        len_wdata = '0;
        if (acc) begin
            o_push = 1'b1;
            unique case (cmd)
                frq_pkg::CMD_APPEND: begin
                    o_job.status = open_rej;
                    o_job.len    = cur_len;
                    if (open_rej == frq_pkg::ST_OK) begin
                        if (cur_len >= eff_limit) begin
                            o_job.status = frq_pkg::ST_TOO_LONG;
                        end else begin
                            o_wr_en   = 1'b1;
                            o_job.len = cur_len + 1'b1;
                        end
                    end
                    if (i_item.last_byte) begin
                        if (o_job.status == frq_pkg::ST_OK) begin
                            len_we    = 1'b1;
                            len_wdata = o_job.len;
                            n_tail    = step_index(r_tail, eff_slots);
                            n_count   = r_count + 1'b1;
                        end
                        n_open   = 1'b0;
                        n_wlen   = '0;
                        n_reject = frq_pkg::ST_OK;
                    end else begin
                        n_open   = 1'b1;
                        n_wlen   = o_job.len;
                        n_reject = o_job.status;
                    end
                end
                frq_pkg::CMD_CLEAR: begin
                    n_head  = r_tail;
                    n_count = '0;
                end
                frq_pkg::CMD_READ, frq_pkg::CMD_DISCARD: begin
                    if (r_count == '0) begin
                        o_job.status = frq_pkg::ST_EMPTY;
                    end else begin
                        o_job.len = head_len;
                        if ((cmd == frq_pkg::CMD_READ) && (head_len != '0)) begin
                            o_job.burst = 1'b1;
                            o_job.slot  = r_head;
                        end
                        n_head  = step_index(r_head, eff_slots);
                        n_count = r_count - 1'b1;
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
        // Outstanding frame reads: one more per burst queued, one less per burst finished.
        priority if ((o_push && o_job.burst) && !i_burst_done) begin
            n_rd_pend = r_rd_pend + 1'b1;
        end else if (!(o_push && o_job.burst) && i_burst_done) begin
            n_rd_pend = r_rd_pend - 1'b1;
        end else begin
            n_rd_pend = r_rd_pend;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_wlen    <= '0;
            r_open    <= 1'b0;
            r_reject  <= frq_pkg::ST_OK;
            r_rd_pend <= '0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_count   <= n_count;
            r_wlen    <= n_wlen;
            r_open    <= n_open;
            r_reject  <= n_reject;
            r_rd_pend <= n_rd_pend;
        end
    end

    // Stored frame lengths, written when a frame is committed.
    always_ff @(posedge i_clk) begin
        if (len_we) begin
            r_len_store[r_tail] <= len_wdata;
        end
    end

    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > frq_pkg::SLOTS_CNT)
    `ASSERT_NEVER(a_pend_bound, i_clk, i_rst_n, r_rd_pend > frq_pkg::PEND_MAX)
    `ASSERT_HOLDS(a_burst_has_frame, i_clk, i_rst_n, (o_push && o_job.burst) |-> (r_count != '0))

endmodule

// ===== design/frq_back.sv =====
// Back end: turns queued jobs into result beats, reading frame bytes through a two-stage pipe.
`include "assert_macros.svh"

module frq_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  frq_pkg::t_job              i_job,
    input  logic                       i_q_empty,
    output logic                       o_pop,
    output logic                       o_burst_done,
    output logic                       o_rd_en,
    output logic [frq_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [frq_pkg::BYTE_W-1:0] i_rd_data,
    frq_out_if.source                  o_result
);

    // Byte position within the burst at the queue head.
    logic [frq_pkg::LEN_W-1:0]  r_idx, n_idx;

    // Stage A: beat whose byte, if any, is in the RAM output register.
    logic                       r_a_vld;
    logic                       r_a_single;
    frq_pkg::t_status           r_a_status;
    logic [frq_pkg::LEN_W-1:0]  r_a_len;
    logic                       r_a_last;

    // Stage B: the output register.
    logic                       r_o_valid;
    frq_pkg::t_status           r_o_status;
    logic [frq_pkg::BYTE_W-1:0] r_o_byte;
    logic                       r_o_bvalid;
    logic [frq_pkg::LEN_W-1:0]  r_o_len;
    logic                       r_o_last;

    logic                       adv_b;
    logic                       a_free;
    logic                       take;
    logic                       burst_last;

    assign adv_b      = !r_o_valid || o_result.ready;
    assign a_free     = !r_a_vld || adv_b;
    assign take       = a_free && !i_q_empty;
    assign burst_last = ((r_idx + 1'b1) == i_job.len);

    // Job issue: a single result pops at once, a burst reads one byte a cycle while stage A is free.
    always_comb begin
        o_pop        = 1'b0;
        o_burst_done = 1'b0;
        o_rd_en      = 1'b0;
        o_rd_addr    = frq_pkg::slot_base(i_job.slot) + frq_pkg::ADDR_W'(r_idx);
        n_idx        = r_idx;
        if (take) begin
            if (i_job.burst) begin
                o_rd_en = 1'b1;
                if (burst_last) begin
                    o_pop        = 1'b1;
                    o_burst_done = 1'b1;
                    n_idx        = '0;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end else begin
                o_pop = 1'b1;
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_a_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (a_free) begin
                r_a_vld <= take;
            end
            if (adv_b) begin
                r_o_valid <= r_a_vld;
            end
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (a_free && take) begin
            r_a_single <= !i_job.burst;
            r_a_status <= i_job.status;
            r_a_len    <= i_job.len;
            r_a_last   <= !i_job.burst || burst_last;
        end
        if (adv_b && r_a_vld) begin
            r_o_status <= r_a_status;
            r_o_byte   <= r_a_single ? '0 : i_rd_data;
            r_o_bvalid <= !r_a_single;
            r_o_len    <= r_a_len;
            r_o_last   <= r_a_last;
        end
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.status       = r_o_status;
    assign o_result.out_byte     = r_o_byte;
    assign o_result.byte_valid   = r_o_bvalid;
    assign o_result.frame_length = r_o_len;
    assign o_result.last         = r_o_last;

    `ASSERT_HOLDS(a_done_pops, i_clk, i_rst_n, o_burst_done |-> o_pop)
    `ASSERT_HOLDS(a_idle_idx_zero, i_clk, i_rst_n, i_q_empty |-> (r_idx == '0))
    `ASSERT_HOLDS(a_byte_has_len, i_clk, i_rst_n, (r_a_vld && !r_a_single) |-> (r_a_len != '0))

endmodule

// ===== bench/tb_frame_ring_queue.sv =====
// Self-checking testbench for the frame ring queue, with its own queue predictor.
`timescale 1ns / 1ps

module tb_frame_ring_queue;
    import frq_pkg::*;

    localparam real CLK_PERIOD    = 12.0;
    localparam int  RESET_CYCLES  = 10;
    localparam int  SETTLE_CYCLES = 8;
    localparam int  DRAIN_LIMIT   = 20000;
    localparam int  LONG_HOLD     = 80;
    localparam int  RUN_LIMIT     = 1000000;

    // Register byte addresses: register i sits at 4*i.
    localparam logic [PADDR_W-1:0] ADDR_ACTIVE_SLOTS = {REG_ACTIVE_SLOTS, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_FRAME_LIMIT  = {REG_FRAME_LIMIT, 2'b00};

    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic [LEN_W-1:0]  frame_length;
        logic              last;
    } t_result_beat;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    frq_in_if  item_if ();
    frq_out_if res_if ();

    frame_ring_queue dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predicted queue state and register copies.
    logic [BYTE_W-1:0] ring_bytes [SLOTS][FRAME_BYTES];
    logic [LEN_W-1:0]  ring_len [SLOTS];
    int unsigned       ring_head;
    int unsigned       ring_tail;
    int                ring_count;
    bit                fill_open;
    int                fill_len;
    t_status           fill_status;
    logic [SLOTS_CFG_W-1:0] cfg_slots;
    logic [LIMIT_CFG_W-1:0] cfg_limit;

    t_result_beat frame_beats_due [$];

    int  send_gap_max;
    int  recv_gap_max;
    bit  hold_request;
    int  mismatches;
    int  items_sent;
    int  beats_checked;
    int  full_seen;
    int  too_long_seen;
    int  empty_seen;

    // Clock.
    initial i_clk = 1'b0;
    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    function automatic int used_slots();
        if (cfg_slots < 1) return 1;
        if (cfg_slots > SLOTS) return SLOTS;
        return int'(cfg_slots);
    endfunction

    function automatic int byte_limit();
        if (cfg_limit < 1) return 1;
        if (cfg_limit > FRAME_BYTES) return FRAME_BYTES;
        return int'(cfg_limit);
    endfunction

    function automatic int unsigned next_slot(input int unsigned slot);
        return (slot + 1 >= used_slots()) ? 0 : slot + 1;
    endfunction

    // Works out the result beats of one accepted item and advances the predicted queue.
    function automatic void advance_frame_queue(input t_cmd cmd, input logic [BYTE_W-1:0] data,
                                                input logic lastb);
        t_result_beat beat;
        int unsigned  slot;
        int           len;
        slot = ring_head;
        beat = '{status: ST_OK, out_byte: '0, byte_valid: 1'b0, frame_length: '0, last: 1'b1};
        case (cmd)
            CMD_APPEND: begin
                if (!fill_open) begin
                    fill_open   = 1'b1;
                    fill_len    = 0;
                    fill_status = (ring_count >= used_slots()) ? ST_FULL : ST_OK;
                end
                if (fill_status == ST_OK) begin
                    if (fill_len >= byte_limit()) begin
                        fill_status = ST_TOO_LONG;
                    end else begin
                        ring_bytes[ring_tail][fill_len] = data;
                        fill_len++;
                    end
                end
                beat.status       = fill_status;
                beat.frame_length = LEN_W'(fill_len);
                if (lastb) begin
                    // The frame is committed only if nothing rejected it.
                    if (fill_status == ST_OK) begin
                        ring_len[ring_tail] = LEN_W'(fill_len);
                        ring_tail = next_slot(ring_tail);
                        ring_count++;
                    end
                    fill_open   = 1'b0;
                    fill_len    = 0;
                    fill_status = ST_OK;
                end
                frame_beats_due.push_back(beat);
            end
            CMD_CLEAR: begin
                ring_head  = ring_tail;
                ring_count = 0;
                frame_beats_due.push_back(beat);
            end
            default: begin
                if (ring_count == 0) begin
                    beat.status = ST_EMPTY;
                    frame_beats_due.push_back(beat);
                end else begin
                    len = int'(ring_len[slot]);
                    if (cmd == CMD_READ && len > 0) begin
                        // A read sends one beat per stored byte.
                        for (int i = 0; i < len; i++) begin
                            beat.out_byte     = ring_bytes[slot][i];
                            beat.byte_valid   = 1'b1;
                            beat.frame_length = LEN_W'(len);
                            beat.last         = (i + 1 == len);
                            frame_beats_due.push_back(beat);
                        end
                    end else begin
                        beat.frame_length = LEN_W'(len);
                        frame_beats_due.push_back(beat);
                    end
                    ring_head = next_slot(slot);
                    ring_count--;
                end
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Every accepted result beat is compared with the oldest predicted one.
    always @(posedge i_clk) begin
        t_result_beat want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (frame_beats_due.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, status %0d, byte %0d",
                         $time, res_if.status, res_if.out_byte);
                mismatches++;
            end else begin
                want = frame_beats_due.pop_front();
                check_field("status", want.status, res_if.status);
                check_field("out_byte", want.out_byte, res_if.out_byte);
                check_field("byte_valid", want.byte_valid, res_if.byte_valid);
                check_field("frame_length", want.frame_length, res_if.frame_length);
                check_field("last", want.last, res_if.last);
                beats_checked++;
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_TOO_LONG) too_long_seen++;
                if (want.status == ST_EMPTY) empty_seen++;
            end
        end
    end

    // Result receiver: random stalls per beat, and a long hold when one is requested.
    initial begin
        int gap;
        res_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = hold_request ? LONG_HOLD : $urandom_range(0, recv_gap_max);
            hold_request = 1'b0;
            if (gap > 0) begin
                @(negedge i_clk);
                res_if.ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    // Offers one item after a random gap and returns once it has been accepted.
    task automatic send_item(input t_cmd cmd, input logic [BYTE_W-1:0] data, input logic lastb);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        @(negedge i_clk);
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.cmd       <= cmd;
        item_if.data_byte <= data;
        item_if.last_byte <= lastb;
        do @(posedge i_clk); while (!item_if.ready);
        advance_frame_queue(cmd, data, lastb);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted beat has arrived.
    task automatic wait_idle();
        int waited;
        @(negedge i_clk);
        item_if.valid <= 1'b0;
        waited = 0;
        while (frame_beats_due.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (frame_beats_due.size() != 0) begin
            $display("%0t ns: %0d result beats never arrived", $time, frame_beats_due.size());
            mismatches++;
            frame_beats_due.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write: setup phase, then access phase.
    task automatic write_reg(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_ACTIVE_SLOTS) cfg_slots = value[SLOTS_CFG_W-1:0];
        else if (addr == ADDR_FRAME_LIMIT) cfg_limit = value[LIMIT_CFG_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int slots_val, input int limit_val);
        wait_idle();
        write_reg(ADDR_ACTIVE_SLOTS, PDATA_W'(slots_val));
        write_reg(ADDR_FRAME_LIMIT, PDATA_W'(limit_val));
    endtask

    // Read, discard and clear on an empty queue, with junk in the ignored fields.
    task automatic test_empty_queue();
        set_config(16, 64);
        send_item(CMD_READ, 8'hFF, 1'b1);
        send_item(CMD_DISCARD, 8'h00, 1'b0);
        send_item(CMD_CLEAR, 8'hFF, 1'b1);
    endtask

    // Frames come back whole and in order.
    task automatic test_frame_order();
        send_item(CMD_APPEND, 8'h00, 1'b1);
        send_item(CMD_APPEND, 8'hFF, 1'b0);
        send_item(CMD_APPEND, 8'h80, 1'b0);
        send_item(CMD_APPEND, 8'h01, 1'b1);
        send_item(CMD_READ, 8'h5A, 1'b0);
        send_item(CMD_READ, 8'hA5, 1'b1);
        send_item(CMD_READ, 8'h00, 1'b0);
    endtask

    // A frame past the limit is truncated in its status and never committed.
    task automatic test_frame_too_long();
        set_config(16, 2);
        send_item(CMD_APPEND, 8'h11, 1'b0);
        send_item(CMD_APPEND, 8'h22, 1'b0);
        send_item(CMD_APPEND, 8'h33, 1'b0);
        send_item(CMD_APPEND, 8'h44, 1'b1);
        send_item(CMD_APPEND, 8'h55, 1'b0);
        send_item(CMD_APPEND, 8'h66, 1'b1);
        send_item(CMD_DISCARD, 8'h77, 1'b1);
        send_item(CMD_DISCARD, 8'h88, 1'b0);
    endtask

    // With one slot the second frame finds the queue full and is dropped whole.
    task automatic test_queue_full();
        set_config(1, 64);
        send_item(CMD_APPEND, 8'hC3, 1'b1);
        send_item(CMD_APPEND, 8'h3C, 1'b0);
        send_item(CMD_APPEND, 8'h99, 1'b1);
        send_item(CMD_READ, 8'h00, 1'b0);
    endtask

    // A clear in the middle of an append leaves the open frame untouched.
    task automatic test_clear_mid_frame();
        send_item(CMD_APPEND, 8'h12, 1'b0);
        send_item(CMD_CLEAR, 8'h00, 1'b0);
        send_item(CMD_APPEND, 8'h34, 1'b1);
        send_item(CMD_READ, 8'hFF, 1'b1);
    endtask

    // One register setting with mostly well-formed frames and some stray commands.
    task automatic run_random_phase(input int slots_val, input int limit_val, input int budget,
                                    input int s_gap, input int r_gap, input bit with_longest);
        int pick;
        int flen;
        // Empty the ring before the slot count changes under it.
        send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
        set_config(slots_val, limit_val);
        send_gap_max = s_gap;
        recv_gap_max = r_gap;
        if (with_longest) begin
            for (int i = 0; i < byte_limit(); i++)
                send_item(CMD_APPEND, 8'($urandom), i == byte_limit() - 1);
            send_item(CMD_READ, 8'($urandom), 1'($urandom));
        end
        while (budget > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 6) == 0 && byte_limit() <= 16)
                    flen = byte_limit() + $urandom_range(0, 1);
                else
                    flen = $urandom_range(1, 6);
                for (int i = 0; i < flen; i++) begin
                    if (i > 0 && $urandom_range(0, 11) == 0) begin
                        send_item(t_cmd'($urandom_range(1, 3)), 8'($urandom), 1'($urandom));
                        budget--;
                    end
                    send_item(CMD_APPEND, 8'($urandom), i == flen - 1);
                    budget--;
                end
            end else begin
                if (pick < 80) send_item(CMD_READ, 8'($urandom), 1'($urandom));
                else if (pick < 90) send_item(CMD_DISCARD, 8'($urandom), 1'($urandom));
                else if (pick < 94) send_item(CMD_CLEAR, 8'($urandom), 1'($urandom));
                else send_item(t_cmd'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
                budget--;
            end
        end
        // Close any frame left open so that the next setting starts clean.
        if (fill_open) send_item(CMD_APPEND, 8'($urandom), 1'b1);
    endtask

    // Several settings, the saturating extremes among them.
    task automatic test_random_traffic();
        run_random_phase(16, 64, 8, 18, 18, 1'b1);
        run_random_phase(3, 8, 8, 0, 0, 1'b0);
        run_random_phase(31, 127, 6, 18, 4, 1'b0);
        run_random_phase(0, 0, 6, 6, 18, 1'b0);
        run_random_phase(2, 5, 8, 18, 0, 1'b0);
    endtask

    // The receiver holds off for a long stretch while appends keep coming.
    task automatic test_back_pressure();
        send_item(CMD_CLEAR, 8'h00, 1'b0);
        set_config(4, 16);
        send_gap_max = 0;
        recv_gap_max = 2;
        hold_request = 1'b1;
        for (int f = 0; f < 6; f++)
            for (int i = 0; i < 3; i++)
                send_item(CMD_APPEND, 8'($urandom), i == 2);
        repeat (4) send_item(CMD_READ, 8'($urandom), 1'($urandom));
        wait_idle();
    endtask

    // Run limit.
    initial begin
        #(RUN_LIMIT * CLK_PERIOD);
        $display("frame_ring_queue regression: fail");
        $finish;
    end

    // Reset, then the tests in turn.
    initial begin
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        item_if.valid     = 1'b0;
        item_if.cmd       = CMD_APPEND;
        item_if.data_byte = '0;
        item_if.last_byte = 1'b0;
        hold_request      = 1'b0;
        send_gap_max      = 3;
        recv_gap_max      = 3;
        mismatches        = 0;
        items_sent        = 0;
        beats_checked     = 0;
        full_seen         = 0;
        too_long_seen     = 0;
        empty_seen        = 0;
        ring_head         = 0;
        ring_tail         = 0;
        ring_count        = 0;
        fill_open         = 1'b0;
        fill_len          = 0;
        fill_status       = ST_OK;
        cfg_slots         = ACTIVE_SLOTS_RST;
        cfg_limit         = FRAME_LIMIT_RST;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_queue();
        test_frame_order();
        test_frame_too_long();
        test_queue_full();
        test_clear_mid_frame();
        test_random_traffic();
        test_back_pressure();
        wait_idle();

        $display("Sent %0d items and checked %0d result beats over nine register settings.",
                 items_sent, beats_checked);
        $display("Answers seen: %0d queue full, %0d too long, %0d empty; %0d mismatches.",
                 full_seen, too_long_seen, empty_seen, mismatches);
        if (mismatches == 0) begin
            $display("frame_ring_queue regression: pass");
        end else begin
            $display("frame_ring_queue regression: fail");
        end
        $finish;
    end

endmodule
